[hw/rtl/i2c_eeprom_target_macros.svh]
// Assertion macros used by the EEPROM target top level.
`ifndef I2C_EEPROM_TARGET_MACROS_SVH
`define I2C_EEPROM_TARGET_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define I2CE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define I2CE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/i2ce_pkg.sv]
// Types and constants for the I2C EEPROM target.
`timescale 1ns / 1ps

package i2ce_pkg;

  localparam int MEM_BYTES_DEF = 512;
  localparam logic [7:0] CTRL_CODE = 8'hA0;

  typedef enum logic [1:0] {
    OP_STOP  = 2'd0,
    OP_START = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RESP_NONE  = 2'd0,
    RESP_ACK   = 2'd1,
    RESP_READ  = 2'd2,
    RESP_RANGE = 2'd3
  } resp_t;

  typedef enum logic [1:0] {
    PH_STOPPED = 2'd0,
    PH_ADDR_HI = 2'd1,
    PH_ADDR_LO = 2'd2,
    PH_DATA    = 2'd3
  } phase_t;

  typedef struct packed {
    logic wr;
    logic rd;
  } mem_ctl_t;

endpackage

[hw/rtl/i2ce_req_if.sv]
// Bus event channel: valid/ready with op, device address and written byte.
`timescale 1ns / 1ps

interface i2ce_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] dev_addr;
  logic [7:0] wr_byte;

  modport source (output valid, op, dev_addr, wr_byte, input ready);
  modport sink (input valid, op, dev_addr, wr_byte, output ready);
endinterface

[hw/rtl/i2ce_rsp_if.sv]
// Response channel: valid/ready with response code and read byte.
`timescale 1ns / 1ps

interface i2ce_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] resp;
  logic [7:0] rd_byte;

  modport source (output valid, resp, rd_byte, input ready);
  modport sink (input valid, resp, rd_byte, output ready);
endinterface

[hw/rtl/i2c_eeprom_target.sv]
// Top level of the I2C serial EEPROM target, one bus event per transfer.
//
//   channel  dir  fields               notes
//   req      in   op, dev_addr, wr_byte  one bus event per transfer
//   rsp      out  resp, rd_byte          exactly one response per event
//
// One event per cycle while rsp is ready and no fill runs; at accept the
// state, memory and s1 register update, then the output register loads.
// The store read port is the registered RAM port; read data lands
// in the cycle after accept.
// After reset a zero-fill sweep over all MEM_BYTES locations runs with req.ready low.
// A stalled rsp holds one result in the output stage and one in flight.
`timescale 1ns / 1ps

module i2c_eeprom_target
  import i2ce_pkg::*;
#(
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input logic        clk,
  input logic        rst,
  i2ce_req_if.sink   req,
  i2ce_rsp_if.source rsp
);

  `include "i2c_eeprom_target_macros.svh"

  localparam int AW = $clog2(MEM_BYTES);
  localparam logic [16:0] LIMIT = 17'(MEM_BYTES);

  phase_t      phase, phase_next;
  logic [15:0] base, base_next;
  logic [15:0] offset, offset_next;

  logic        s1_valid;
  resp_t       s1_resp;
  logic        s1_adv;
  logic        out_valid;
  resp_t       out_resp;
  logic [7:0]  out_rd;

  logic        acc;
  op_t         op;
  logic [16:0] loc;
  logic        in_range;
  resp_t       resp_d;
  mem_ctl_t    mctl;
  logic [7:0]  rdata;
  logic        clearing;

  assign op       = op_t'(req.op);
  assign loc      = {1'b0, base} + {1'b0, offset};
  assign in_range = loc < LIMIT;
  assign s1_adv   = !out_valid || rsp.ready;
  assign req.ready = !clearing && (!s1_valid || s1_adv);
  assign acc      = req.valid && req.ready;

  // next state
  always_comb begin
    phase_next  = phase;
    base_next   = base;
    offset_next = offset;
    if (acc) begin
      case (op)
        OP_STOP: begin
          phase_next  = PH_STOPPED;
          base_next   = '0;
          offset_next = '0;
        end
        OP_START: begin
          if ((req.dev_addr & CTRL_CODE) != 8'h00) begin
            phase_next = req.dev_addr[0] ? PH_DATA : PH_ADDR_HI;
          end
        end
        OP_WRITE: begin
          case (phase)
            PH_ADDR_HI: begin
              base_next  = {req.wr_byte, 8'h00};
              phase_next = PH_ADDR_LO;
            end
            PH_ADDR_LO: begin
              base_next  = base | {8'h00, req.wr_byte};
              phase_next = PH_DATA;
            end
            PH_DATA: begin
              if (in_range) begin
                offset_next = offset + 16'd1;
              end
            end
            default: ;
          endcase
        end
        OP_READ: begin
          if (in_range) begin
            offset_next = offset + 16'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // response code and store access
  always_comb begin
    resp_d  = RESP_NONE;
    mctl.wr = 1'b0;
    mctl.rd = 1'b0;
    case (op)
      OP_STOP: resp_d = RESP_NONE;
      OP_START: begin
        if ((req.dev_addr & CTRL_CODE) != 8'h00) begin
          resp_d = RESP_ACK;
        end
      end
      OP_WRITE: begin
        resp_d = RESP_ACK;
        if (phase == PH_DATA) begin
          if (in_range) begin
            mctl.wr = acc;
          end else begin
            resp_d = RESP_RANGE;
          end
        end
      end
      OP_READ: begin
        if (in_range) begin
          resp_d  = RESP_READ;
          mctl.rd = acc;
        end else begin
          resp_d = RESP_RANGE;
        end
      end
      default: resp_d = RESP_NONE;
    endcase
  end

  i2ce_mem #(
    .MEM_BYTES(MEM_BYTES)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mctl),
    .addr    (loc[AW-1:0]),
    .wdata   (req.wr_byte),
    .rdata   (rdata),
    .clearing(clearing)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_STOPPED;
      base      <= '0;
      offset    <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      phase  <= phase_next;
      base   <= base_next;
      offset <= offset_next;
      if (acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_resp <= resp_d;
    end
    if (s1_adv && s1_valid) begin
      out_resp <= s1_resp;
      out_rd   <= (s1_resp == RESP_READ) ? rdata : 8'h00;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.resp    = out_resp;
  assign rsp.rd_byte = out_rd;

  `I2CE_ASSERT_NOW(a_no_accept_clearing, clearing, !req.ready, "event accepted during fill")
  `I2CE_ASSERT_NXT(a_s1_held, s1_valid && !s1_adv, s1_valid, "in-flight result dropped")
  `I2CE_ASSERT_NXT(a_stop_clears, acc && op == OP_STOP, phase == PH_STOPPED && base == 16'h0000 && offset == 16'h0000, "stop did not clear state")
  `I2CE_ASSERT_NOW(a_rd_zero, out_valid && out_resp != RESP_READ, out_rd == 8'h00, "nonzero byte without read")
  `I2CE_ASSERT_NOW(a_one_access, 1'b1, !(mctl.wr && mctl.rd), "write and read in one cycle")

endmodule

[hw/rtl/i2ce_mem.sv]
// Byte store with registered read and a zero-fill sweep after reset.
`timescale 1ns / 1ps

module i2ce_mem
  import i2ce_pkg::*;
#(
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mem_ctl_t                     ctl,
  input  logic [$clog2(MEM_BYTES)-1:0] addr,
  input  logic [7:0]                   wdata,
  output logic [7:0]                   rdata,
  output logic                         clearing
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam logic [AW-1:0] LAST = AW'(MEM_BYTES - 1);

  logic [7:0]    mem [MEM_BYTES];
  logic [AW-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + AW'(1);
      if (clr_cnt == LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt] <= 8'h00;
    end else if (ctl.wr) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule
